// ===== rtl/dds_mix_pkg.sv =====
`default_nettype none
package dds_mix_pkg;

  localparam int unsigned NUM_OSC    = 3;
  localparam int unsigned OSC_IDX_W  = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [11:0] FULL_SCALE = 12'hFFF;
  localparam logic [31:0] LFSR_TAPS  = 32'h8020_0003;
  localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
  localparam logic [31:0] SIN_A      = 32'd1686629713;
  localparam logic [31:0] SIN_B      = 32'd693598670;
  localparam logic [31:0] SIN_C      = 32'd85569304;
  localparam logic [30:0] SIN_D      = 31'd5026996;

  typedef enum logic [2:0] {
    REG_SHAPE_A  = 3'd0,
    REG_SHAPE_B  = 3'd1,
    REG_SHAPE_C  = 3'd2,
    REG_OFFSET_A = 3'd3,
    REG_OFFSET_B = 3'd4,
    REG_OFFSET_C = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    SHAPE_SINE     = 3'd0,
    SHAPE_TRIANGLE = 3'd1,
    SHAPE_SAW_UP   = 3'd2,
    SHAPE_SAW_DOWN = 3'd3,
    SHAPE_SQUARE   = 3'd4,
    SHAPE_NOISE    = 3'd5
  } shape_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADV,
    ST_IDX,
    ST_WAVE,
    ST_SIN2,
    ST_SIN3,
    ST_SIN4,
    ST_SIN5,
    ST_SIN6,
    ST_GAIN,
    ST_ACC,
    ST_MIX,
    ST_DONE
  } ctrl_state_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_R_R,
    MUL_X2_D,
    MUL_X2_C,
    MUL_X2_B,
    MUL_R_A,
    MUL_GAIN,
    MUL_MASTER
  } mul_op_e;

  typedef struct packed {
    logic [31:0] step_a;
    logic [31:0] step_b;
    logic [31:0] step_c;
    logic [16:0] width_a;
    logic [16:0] width_b;
    logic [16:0] width_c;
    logic [8:0]  gain_a;
    logic [8:0]  gain_b;
    logic [8:0]  gain_c;
    logic [8:0]  master_gain;
  } in_item_t;

  typedef struct packed {
    logic [11:0] level;
    logic [15:0] dac_code;
    logic        clipped;
  } out_item_t;

  typedef struct packed {
    logic    load;
    logic    advance;
    logic    index;
    logic    wave;
    mul_op_e mul_op;
    logic    keep_x2;
    logic    sine_done;
    logic    accumulate;
    logic    next_osc;
    logic    finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_sine;
    logic last_osc;
  } dp_sts_t;

  function automatic logic [15:0] dac_of(input logic [11:0] lvl);
    logic [15:0] b;
    b = {4'b0, lvl} + 16'd256;
    return (b << 4) - (b << 1);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/dds_mix_ctrl.sv =====
`default_nettype none
module dds_mix_ctrl import dds_mix_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire dp_sts_t    sts_i,
  output ctrl_cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.mul_op = MUL_NONE;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ADV;
        end
      end
      ST_ADV: begin
        cmd_o.advance = 1'b1;
        state_d       = ST_IDX;
      end
      ST_IDX: begin
        cmd_o.index = 1'b1;
        state_d     = ST_WAVE;
      end
      ST_WAVE: begin
        if (sts_i.is_sine) begin
          cmd_o.mul_op = MUL_R_R;
          state_d      = ST_SIN2;
        end else begin
          cmd_o.wave = 1'b1;
          state_d    = ST_GAIN;
        end
      end
      ST_SIN2: begin
        cmd_o.mul_op  = MUL_X2_D;
        cmd_o.keep_x2 = 1'b1;
        state_d       = ST_SIN3;
      end
      ST_SIN3: begin
        cmd_o.mul_op = MUL_X2_C;
        state_d      = ST_SIN4;
      end
      ST_SIN4: begin
        cmd_o.mul_op = MUL_X2_B;
        state_d      = ST_SIN5;
      end
      ST_SIN5: begin
        cmd_o.mul_op = MUL_R_A;
        state_d      = ST_SIN6;
      end
      ST_SIN6: begin
        cmd_o.sine_done = 1'b1;
        state_d         = ST_GAIN;
      end
      ST_GAIN: begin
        cmd_o.mul_op = MUL_GAIN;
        state_d      = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.accumulate = 1'b1;
        if (sts_i.last_osc) begin
          state_d = ST_MIX;
        end else begin
          cmd_o.next_osc = 1'b1;
          state_d        = ST_ADV;
        end
      end
      ST_MIX: begin
        cmd_o.mul_op = MUL_MASTER;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== rtl/dds_mix_dp.sv =====
`default_nettype none
module dds_mix_dp import dds_mix_pkg::*; #(
  parameter int unsigned TABLE_ADDR_BITS = 16,
  parameter int unsigned OSC_COUNT       = 3
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire in_item_t              in_data_i,
  input  wire ctrl_cmd_t             cmd_i,
  output dp_sts_t                    sts_o,
  output out_item_t                  out_data_o
);

  localparam logic [15:0] PhaseMask =
    16'(((32'd1 << TABLE_ADDR_BITS) - 32'd1) << (16 - TABLE_ADDR_BITS));

  logic [2:0]           shape_q  [NUM_OSC];
  logic [31:0]          offset_q [NUM_OSC];
  logic [31:0]          acc_q    [OSC_COUNT];
  in_item_t             in_q;
  logic [OSC_IDX_W-1:0] osc_q;
  logic [15:0]          p_q;
  logic [11:0]          v_q;
  logic [30:0]          x2_q;
  logic [61:0]          prod_q;
  logic [14:0]          sum_q;
  logic [31:0]          lfsr_q;
  out_item_t            out_q;

  logic [31:0] step_sel, acc_sel, offset_sel, phase_sum, lfsr_n;
  logic [16:0] width_sel;
  logic [8:0]  gain_sel;
  logic [2:0]  shape_sel;
  logic [14:0] r_val;
  logic [30:0] mul_a, mul_b, s_cap;
  logic [31:0] t_base, t_full, s_raw;
  logic [41:0] mag_full;
  logic [11:0] mag, v_sine, v_direct, noise_v, level;
  logic [16:0] mixed;
  logic        clip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_OSC; k++) begin
        shape_q[k]  <= '0;
        offset_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SHAPE_A:  shape_q[0]  <= cfg_data_i[2:0];
        REG_SHAPE_B:  shape_q[1]  <= cfg_data_i[2:0];
        REG_SHAPE_C:  shape_q[2]  <= cfg_data_i[2:0];
        REG_OFFSET_A: offset_q[0] <= cfg_data_i;
        REG_OFFSET_B: offset_q[1] <= cfg_data_i;
        REG_OFFSET_C: offset_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    step_sel  = '0;
    width_sel = '0;
    gain_sel  = '0;
    case (osc_q)
      2'd0: begin
        step_sel  = in_q.step_a;
        width_sel = in_q.width_a;
        gain_sel  = in_q.gain_a;
      end
      2'd1: begin
        step_sel  = in_q.step_b;
        width_sel = in_q.width_b;
        gain_sel  = in_q.gain_b;
      end
      2'd2: begin
        step_sel  = in_q.step_c;
        width_sel = in_q.width_c;
        gain_sel  = in_q.gain_c;
      end
      default: ;
    endcase
  end

  assign shape_sel  = shape_q[osc_q];
  assign offset_sel = offset_q[osc_q];

  always_comb begin
    acc_sel = '0;
    for (int k = 0; k < OSC_COUNT; k++) begin
      if (osc_q == OSC_IDX_W'(k)) acc_sel = acc_q[k];
    end
  end

  for (genvar g = 0; g < OSC_COUNT; g++) begin : g_acc
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        acc_q[g] <= '0;
      end else if (cmd_i.advance && osc_q == OSC_IDX_W'(g)) begin
        acc_q[g] <= acc_q[g] + step_sel;
      end
    end
  end

  assign phase_sum = acc_sel + offset_sel;

  assign lfsr_n = {1'b0, lfsr_q[31:1]} ^ (lfsr_q[0] ? LFSR_TAPS : 32'd0);
  assign noise_v = (lfsr_n[11:0] == FULL_SCALE) ? 12'd0 : lfsr_n[11:0];

  always_comb begin
    unique case (shape_sel)
      SHAPE_TRIANGLE: v_direct = p_q[15] ? ~p_q[14:3] : p_q[14:3];
      SHAPE_SAW_UP:   v_direct = p_q[15:4];
      SHAPE_SAW_DOWN: v_direct = ~p_q[15:4];
      SHAPE_SQUARE:   v_direct = ({1'b0, p_q} < width_sel) ? FULL_SCALE : 12'd0;
      SHAPE_NOISE:    v_direct = noise_v;
      default:        v_direct = 12'd0;
    endcase
  end

  assign r_val = p_q[14] ? (15'd16384 - {1'b0, p_q[13:0]}) : {1'b0, p_q[13:0]};

  always_comb begin
    unique case (cmd_i.mul_op)
      MUL_X2_C: t_base = SIN_C;
      MUL_X2_B: t_base = SIN_B;
      default:  t_base = SIN_A;
    endcase
    t_full = t_base - prod_q[61:30];
  end

  always_comb begin
    unique case (cmd_i.mul_op)
      MUL_R_R: begin
        mul_a = {16'b0, r_val};
        mul_b = {16'b0, r_val};
      end
      MUL_X2_D: begin
        mul_a = {prod_q[28:0], 2'b00};
        mul_b = SIN_D;
      end
      MUL_X2_C, MUL_X2_B: begin
        mul_a = x2_q;
        mul_b = t_full[30:0];
      end
      MUL_R_A: begin
        mul_a = {16'b0, r_val};
        mul_b = t_full[30:0];
      end
      MUL_GAIN: begin
        mul_a = {19'b0, v_q};
        mul_b = {22'b0, gain_sel};
      end
      MUL_MASTER: begin
        mul_a = {16'b0, sum_q};
        mul_b = {22'b0, in_q.master_gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign s_raw    = prod_q[45:14];
  assign s_cap    = (s_raw > {1'b0, Q30_ONE}) ? Q30_ONE : s_raw[30:0];
  assign mag_full = {s_cap, 11'b0} - {11'b0, s_cap} + 42'h0_2000_0000;
  assign mag      = mag_full[41:30];
  assign v_sine   = p_q[15] ? (12'd2048 - mag) : (12'd2048 + mag);

  assign mixed = prod_q[23:7];
  assign clip  = |mixed[16:12];
  assign level = clip ? FULL_SCALE : mixed[11:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      osc_q  <= '0;
      sum_q  <= '0;
      lfsr_q <= 32'd1;
    end else begin
      if (cmd_i.load) begin
        osc_q <= '0;
        sum_q <= '0;
      end
      if (cmd_i.next_osc) osc_q <= osc_q + OSC_IDX_W'(1);
      if (cmd_i.accumulate) sum_q <= sum_q + {2'b0, prod_q[20:8]};
      if (cmd_i.wave && shape_sel == SHAPE_NOISE) lfsr_q <= lfsr_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) in_q <= in_data_i;
    if (cmd_i.index) p_q <= phase_sum[31:16] & PhaseMask;
    if (cmd_i.wave) v_q <= v_direct;
    if (cmd_i.sine_done) v_q <= v_sine;
    if (cmd_i.keep_x2) x2_q <= {prod_q[28:0], 2'b00};
    if (cmd_i.mul_op != MUL_NONE) prod_q <= mul_a * mul_b;
    if (cmd_i.finish) begin
      out_q.level    <= level;
      out_q.dac_code <= dac_of(level);
      out_q.clipped  <= clip;
    end
  end

  assign sts_o.is_sine  = (shape_sel == SHAPE_SINE);
  assign sts_o.last_osc = (osc_q == OSC_IDX_W'(OSC_COUNT - 1));
  assign out_data_o     = out_q;

endmodule
`default_nettype wire

// ===== rtl/three_osc_dds_mixer_top.sv =====
// Three-oscillator DDS mixer.
// Input channel in_valid_i/in_ready_o carries one sample-tick request with
// tuning words, pulse widths, per-oscillator gains and the master gain.
// Output channel out_valid_o/out_ready_i returns one sample per request:
// limited level, DAC word and clip flag.
// Waveform shape and phase offset per oscillator are set through the write
// port (cfg_we_i, cfg_idx_i, cfg_data_i); the user writes them only while
// no request is in flight (not enforced by the block). One request is
// worked at a time by a state machine that drives a single shared 31x31
// multiplier. Each oscillator steps through the advance, index, waveform,
// gain and accumulate states, and also through SIN2 to SIN6 when it plays
// sine (polynomial evaluated over five multiplies). The next request is
// taken in the cycle after the result is loaded into the output register.
// A finished sample waits in the output register while the receiver stalls;
// a new request is accepted meanwhile, and its result is held back until
// the previous one is taken.
// Reset clears phase accumulators, shapes and offsets, and sets the noise
// register to one.
`default_nettype none
module three_osc_dds_mixer_top import dds_mix_pkg::*; #(
  parameter int unsigned TABLE_ADDR_BITS = 16,
  parameter int unsigned OSC_COUNT       = 3
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_item_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_item_t                  out_data_o
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  dds_mix_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dds_mix_dp #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .OSC_COUNT       (OSC_COUNT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while previous request still in work");

  a_clip_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.clipped |-> out_data_o.level == FULL_SCALE)
    else $error("clip flag set without saturated level");

  a_dac_matches_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.dac_code == dac_of(out_data_o.level))
    else $error("DAC word does not match level");
`endif

endmodule
`default_nettype wire
